@@ rtl/cch_pkg.sv @@
package cch_pkg;

    localparam int INDEX_BITS   = 10;
    localparam int PROBE_LIMIT  = 8;
    localparam int TABLE_SIZE   = 1 << INDEX_BITS;
    localparam int PROBE_CNT_W  = $clog2(PROBE_LIMIT + 1);
    localparam int PROBE_SUM_W  = INDEX_BITS + PROBE_CNT_W;

    localparam int CMD_W        = 2;
    localparam int ADDR_W       = 64;
    localparam int CH_W         = 3;
    localparam int EPOCH_W      = 32;
    localparam int CNT_W        = 64;
    localparam int STATUS_W     = 3;
    localparam int HALF_W       = 32;
    localparam int NUM_COUNTERS = 4;
    localparam int CIDX_W       = $clog2(NUM_COUNTERS);

    // Fibonacci hashing multiplier, 2^64 divided by the golden ratio.
    localparam logic [ADDR_W-1:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLAIM  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_COUNT  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    localparam logic [CH_W-1:0] CHAN_NONE        = 3'd0;
    localparam logic [CH_W-1:0] CHAN_TRACE       = 3'd1;
    localparam logic [CH_W-1:0] CHAN_ALLOC_WATER = 3'd2;
    localparam logic [CH_W-1:0] CHAN_COMPACT     = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_KEPT     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [CH_W-1:0]    chan;
        logic [EPOCH_W-1:0] epoch;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic                  done;
        logic [INDEX_BITS-1:0] home;
    } hash_rsp_t;

    // Channels trace through compact each own a claim counter.
    function automatic logic counted_channel(input logic [CH_W-1:0] ch);
        return (ch >= CHAN_TRACE) && (ch <= CHAN_COMPACT);
    endfunction

    function automatic logic [CIDX_W-1:0] counter_index(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] idx;
        idx = ch - CHAN_TRACE;
        return idx[CIDX_W-1:0];
    endfunction

endpackage

@@ rtl/cch_if.sv @@
interface cch_req_if;
    import cch_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [ADDR_W-1:0]    object_address;
    logic [CH_W-1:0]      channel;
    logic [EPOCH_W-1:0]   gc_epoch;

    modport source (output valid, command, object_address, channel, gc_epoch, input ready);
    modport sink   (input valid, command, object_address, channel, gc_epoch, output ready);
endinterface

interface cch_rsp_if;
    import cch_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [CH_W-1:0]      channel_out;
    logic [EPOCH_W-1:0]   epoch_out;
    logic [CNT_W-1:0]     counter_value;
    logic [STATUS_W-1:0]  claim_status;

    modport source (output valid, found, channel_out, epoch_out, counter_value, claim_status,
                    input ready);
    modport sink   (input valid, found, channel_out, epoch_out, counter_value, claim_status,
                    output ready);
endinterface

interface cch_cfg_if;
    logic valid;
    logic ready;
    logic enable;

    modport source (output valid, enable, input ready);
    modport sink   (input valid, enable, output ready);
endinterface

@@ rtl/cch_ram.sv @@
module cch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/cch_hash.sv @@
module cch_hash (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cch_pkg::ADDR_W-1:0] addr,
    output cch_pkg::hash_rsp_t         rsp
);
    import cch_pkg::*;

    // Only the upper half of the 64-bit product matters for the home slot, so the
    // shared 32x32 multiplier forms the low product and the two cross products.
    typedef enum logic [1:0] {
        STEP_LO,
        STEP_CROSS_A,
        STEP_CROSS_B,
        STEP_SUM
    } step_t;

    step_t               step_reg;
    logic                busy_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [2*HALF_W-1:0] prod_reg;
    logic [HALF_W-1:0]   acc_reg;

    logic [HALF_W-1:0]   op_a;
    logic [HALF_W-1:0]   op_b;
    logic [2*HALF_W-1:0] prod;
    logic [HALF_W-1:0]   acc_sum;

    always_comb
    begin
        case (step_reg)
            STEP_LO:
            begin
                op_a = addr_reg[HALF_W-1:0];
                op_b = FIB_MULT[HALF_W-1:0];
            end
            STEP_CROSS_A:
            begin
                op_a = addr_reg[HALF_W-1:0];
                op_b = FIB_MULT[2*HALF_W-1:HALF_W];
            end
            default:
            begin
                op_a = addr_reg[2*HALF_W-1:HALF_W];
                op_b = FIB_MULT[HALF_W-1:0];
            end
        endcase
    end

    assign prod    = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
    assign acc_sum = acc_reg + prod_reg[HALF_W-1:0];

    assign rsp.done = busy_reg && (step_reg == STEP_SUM);
    assign rsp.home = acc_sum[HALF_W-1 -: INDEX_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_LO;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_LO;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                STEP_LO:      step_reg <= STEP_CROSS_A;
                STEP_CROSS_A: step_reg <= STEP_CROSS_B;
                STEP_CROSS_B: step_reg <= STEP_SUM;
                default:
                begin
                    step_reg <= STEP_LO;
                    busy_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg <= addr;
        end
        prod_reg <= prod;
        if (step_reg == STEP_CROSS_A)
        begin
            acc_reg <= prod_reg[2*HALF_W-1:HALF_W];
        end
        else
        begin
            acc_reg <= acc_sum;
        end
    end

endmodule

@@ rtl/claim_channel_hash_table_unit.sv @@
// Sequence: a hashed claim or lookup is hashed after acceptance, then the first slot read is
// issued, the probes are checked in turn with each read overlapping the previous check, and
// the result is posted. Ignored claims, lookups of address zero, counter reads and unused
// commands skip hashing and probing and go straight to posting. One item at a time: the next
// item is not taken until the last result has moved to the output register.
// Reset: counters and enable clear at once; a clearing pass then zeroes every slot.
module claim_channel_hash_table_unit (
    input logic      clk,
    input logic      rst_n,
    cch_req_if.sink  req,
    cch_rsp_if.source rsp,
    cch_cfg_if.sink  cfg
);
    import cch_pkg::*;

    // The sequencer: sweep the memory after reset, wait for an item, hash its address,
    // probe the window, then hand the result to the output register.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [INDEX_BITS-1:0]   clr_idx_reg, clr_idx_next;
    logic                    enable_reg, enable_next;

    cmd_t                    cmd_reg, cmd_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic [EPOCH_W-1:0]      epoch_reg, epoch_next;

    logic [INDEX_BITS-1:0]   home_reg, home_next;
    logic [PROBE_CNT_W-1:0]  issue_n_reg, issue_n_next;
    logic                    chk_v_reg, chk_v_next;
    logic [PROBE_CNT_W-1:0]  chk_n_reg, chk_n_next;
    logic [INDEX_BITS-1:0]   chk_slot_reg, chk_slot_next;

    logic [CNT_W-1:0]        counters_reg [NUM_COUNTERS];
    logic [CNT_W-1:0]        counters_next [NUM_COUNTERS];

    // Result being built for the item in flight.
    logic                    res_found_reg, res_found_next;
    logic [CH_W-1:0]         res_ch_reg, res_ch_next;
    logic [EPOCH_W-1:0]      res_epoch_reg, res_epoch_next;
    logic [CNT_W-1:0]        res_cnt_reg, res_cnt_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;

    // Output register, so a finished result can wait while the next item is taken.
    logic                    out_valid_reg, out_valid_next;
    logic                    out_found_reg, out_found_next;
    logic [CH_W-1:0]         out_ch_reg, out_ch_next;
    logic [EPOCH_W-1:0]      out_epoch_reg, out_epoch_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;

    logic                    hash_start;
    hash_rsp_t               hash_rsp;

    logic                    ram_we;
    logic [INDEX_BITS-1:0]   ram_waddr;
    logic [SLOT_W-1:0]       ram_wdata;
    logic [INDEX_BITS-1:0]   ram_raddr;
    logic [SLOT_W-1:0]       ram_rdata;

    slot_t                   rd_slot;
    logic [PROBE_SUM_W-1:0]  issue_sum;
    logic                    accept;

    cch_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .addr  (req.object_address),
        .rsp   (hash_rsp)
    );

    cch_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.channel_out   = out_ch_reg;
    assign rsp.epoch_out     = out_epoch_reg;
    assign rsp.counter_value = out_cnt_reg;
    assign rsp.claim_status  = out_status_reg;

    // Reads are issued one slot ahead of the check, so the read of the next slot overlaps the check of this one.
    assign issue_sum = PROBE_SUM_W'(home_reg) + PROBE_SUM_W'(issue_n_reg);
    assign ram_raddr = issue_sum[INDEX_BITS-1:0];
    assign rd_slot   = slot_t'(ram_rdata);

    always_comb
    begin
        logic             hit;
        logic             empty;
        logic             last;
        logic             upd;
        slot_t            new_slot;

        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        enable_next     = enable_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        ch_next         = ch_reg;
        epoch_next      = epoch_reg;
        home_next       = home_reg;
        issue_n_next    = issue_n_reg;
        chk_v_next      = chk_v_reg;
        chk_n_next      = chk_n_reg;
        chk_slot_next   = chk_slot_reg;
        counters_next   = counters_reg;
        res_found_next  = res_found_reg;
        res_ch_next     = res_ch_reg;
        res_epoch_next  = res_epoch_reg;
        res_cnt_next    = res_cnt_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_ch_next     = out_ch_reg;
        out_epoch_next  = out_epoch_reg;
        out_cnt_next    = out_cnt_reg;
        out_status_next = out_status_reg;

        hash_start = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = chk_slot_reg;
        ram_wdata  = '0;

        hit      = (rd_slot.addr == addr_reg);
        empty    = (rd_slot.addr == '0);
        last     = (chk_n_reg == PROBE_CNT_W'(PROBE_LIMIT - 1));
        upd      = (ch_reg == CHAN_TRACE) ||
                   ((ch_reg == CHAN_COMPACT) && (rd_slot.chan != CHAN_TRACE));
        new_slot = '{addr: addr_reg, chan: ch_reg, epoch: epoch_reg};

        if (cfg.valid)
        begin
            enable_next = cfg.enable;
        end

        // A posted result leaves once the consumer takes it.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd_t'(req.command);
                    addr_next       = req.object_address;
                    ch_next         = req.channel;
                    epoch_next      = req.gc_epoch;
                    res_found_next  = 1'b0;
                    res_ch_next     = CHAN_NONE;
                    res_epoch_next  = '0;
                    res_cnt_next    = '0;
                    res_status_next = STAT_IGNORED;
                    state_next      = S_DONE;
                    case (cmd_t'(req.command))
                        CMD_CLAIM:
                        begin
                            if (enable_reg && (req.object_address != '0))
                            begin
                                hash_start      = 1'b1;
                                res_status_next = STAT_DROPPED;
                                state_next      = S_HASH;
                                // The counter counts the claim even if the window is full.
                                if (counted_channel(req.channel))
                                begin
                                    counters_next[counter_index(req.channel)] =
                                        counters_reg[counter_index(req.channel)] + 1'b1;
                                end
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (req.object_address != '0)
                            begin
                                hash_start = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                        CMD_COUNT:
                        begin
                            if (counted_channel(req.channel))
                            begin
                                res_cnt_next = counters_reg[counter_index(req.channel)];
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_HASH:
            begin
                if (hash_rsp.done)
                begin
                    home_next    = hash_rsp.home;
                    issue_n_next = '0;
                    chk_v_next   = 1'b0;
                    state_next   = S_PROBE;
                end
            end

            S_PROBE:
            begin
                chk_v_next    = (issue_n_reg < PROBE_CNT_W'(PROBE_LIMIT));
                chk_n_next    = issue_n_reg;
                chk_slot_next = issue_sum[INDEX_BITS-1:0];
                if (issue_n_reg < PROBE_CNT_W'(PROBE_LIMIT))
                begin
                    issue_n_next = issue_n_reg + 1'b1;
                end

                if (chk_v_reg)
                begin
                    if (cmd_reg == CMD_CLAIM)
                    begin
                        if (empty)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata       = new_slot;
                            res_status_next = STAT_INSERTED;
                            state_next      = S_DONE;
                        end
                        else if (hit)
                        begin
                            if (upd)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = new_slot;
                                res_status_next = STAT_UPDATED;
                            end
                            else
                            begin
                                res_status_next = STAT_KEPT;
                            end
                            state_next = S_DONE;
                        end
                        else if (last)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        // A lookup keeps going past empty slots to the end of the window.
                        if (hit)
                        begin
                            res_found_next = 1'b1;
                            res_ch_next    = rd_slot.chan;
                            res_epoch_next = rd_slot.epoch;
                            state_next     = S_DONE;
                        end
                        else if (last)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_ch_next     = res_ch_reg;
                    out_epoch_next  = res_epoch_reg;
                    out_cnt_next    = res_cnt_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            enable_reg     <= 1'b0;
            cmd_reg        <= CMD_NOP;
            addr_reg       <= '0;
            ch_reg         <= CHAN_NONE;
            epoch_reg      <= '0;
            home_reg       <= '0;
            issue_n_reg    <= '0;
            chk_v_reg      <= 1'b0;
            chk_n_reg      <= '0;
            chk_slot_reg   <= '0;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                counters_reg[i] <= '0;
            end
            res_found_reg  <= 1'b0;
            res_ch_reg     <= CHAN_NONE;
            res_epoch_reg  <= '0;
            res_cnt_reg    <= '0;
            res_status_reg <= STAT_IGNORED;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_ch_reg     <= CHAN_NONE;
            out_epoch_reg  <= '0;
            out_cnt_reg    <= '0;
            out_status_reg <= STAT_IGNORED;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            enable_reg     <= enable_next;
            cmd_reg        <= cmd_next;
            addr_reg       <= addr_next;
            ch_reg         <= ch_next;
            epoch_reg      <= epoch_next;
            home_reg       <= home_next;
            issue_n_reg    <= issue_n_next;
            chk_v_reg      <= chk_v_next;
            chk_n_reg      <= chk_n_next;
            chk_slot_reg   <= chk_slot_next;
            counters_reg   <= counters_next;
            res_found_reg  <= res_found_next;
            res_ch_reg     <= res_ch_next;
            res_epoch_reg  <= res_epoch_next;
            res_cnt_reg    <= res_cnt_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_ch_reg     <= out_ch_next;
            out_epoch_reg  <= out_epoch_next;
            out_cnt_reg    <= out_cnt_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule
